@@ src/dcs_pkg.sv @@
// Shared types and constants for the DDS channel command serializer.
package dcs_pkg;

	localparam int unsigned REF_CLOCK_HZ_DEF = 500000000;
	localparam int unsigned QUEUE_DEPTH_DEF  = 2;

	localparam int VAL_W  = 28;
	localparam int REM_W  = 30;
	localparam int WORD_W = 32;
	localparam int IDX_W  = 3;
	localparam int OUT_W  = 16;
	localparam int IN_W   = 32;

	localparam logic [VAL_W-1:0] FREQ_MAX  = 28'd250000000;
	localparam logic [VAL_W-1:0] PHASE_MAX = 28'd16383;
	localparam logic [VAL_W-1:0] AMP_MAX   = 28'd1023;

	localparam logic [15:0] AMP_ENABLE = 16'h1000;
	localparam logic [7:0]  SEL_BASE   = 8'h10;
	localparam logic [7:0]  ADDR_CSEL  = 8'h00;
	localparam logic [7:0]  ADDR_FREQ  = 8'h04;
	localparam logic [7:0]  ADDR_PHASE = 8'h05;
	localparam logic [7:0]  ADDR_AMP   = 8'h06;

	// byte positions inside one command
	localparam logic [IDX_W-1:0] POS_CSEL_ADDR = 3'd0;
	localparam logic [IDX_W-1:0] POS_CSEL_DATA = 3'd1;
	localparam logic [IDX_W-1:0] POS_REG_ADDR  = 3'd2;
	localparam logic [IDX_W-1:0] POS_FREQ_END  = 3'd6;
	localparam logic [IDX_W-1:0] POS_PHASE_END = 3'd4;
	localparam logic [IDX_W-1:0] POS_AMP_END   = 3'd5;

	typedef enum logic [1:0] {
		OP_FREQ  = 2'd0,
		OP_PHASE = 2'd1,
		OP_AMP   = 2'd2
	} dcs_op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_SEND
	} dcs_bk_state_t;

	// classified command held in the queue
	typedef struct packed {
		dcs_op_t          op;
		logic [1:0]       ch;
		logic [VAL_W-1:0] val;   // already saturated
		logic             sat;   // tuning word saturates to all ones
	} dcs_cmd_t;

endpackage

@@ src/dcs_front.sv @@
// Front end: accepts commands, saturates values, drops unused operations.
module dcs_front #(
	parameter int unsigned REF_CLOCK_HZ = dcs_pkg::REF_CLOCK_HZ_DEF
) (
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [dcs_pkg::IN_W-1:0]   s_tdata,
	input  logic [1:0]                 s_tuser,
	input  logic                       q_full,
	output logic                       q_push,
	output dcs_pkg::dcs_cmd_t          q_cmd
);

	localparam logic [dcs_pkg::REM_W-1:0] RefC = dcs_pkg::REM_W'(REF_CLOCK_HZ);

	dcs_pkg::dcs_op_t              op;
	logic [1:0]                    ch;
	logic [dcs_pkg::VAL_W-1:0]     val;
	logic [dcs_pkg::VAL_W-1:0]     val_sat;
	logic                          op_ok;

	assign op  = dcs_pkg::dcs_op_t'(s_tuser);
	assign ch  = s_tdata[1:0];
	assign val = s_tdata[dcs_pkg::VAL_W+1:2];

	always_comb begin
		val_sat = val;
		op_ok   = 1'b1;
		case (op)
			dcs_pkg::OP_FREQ: begin
				if (val > dcs_pkg::FREQ_MAX) val_sat = dcs_pkg::FREQ_MAX;
			end
			dcs_pkg::OP_PHASE: begin
				if (val > dcs_pkg::PHASE_MAX) val_sat = dcs_pkg::PHASE_MAX;
			end
			dcs_pkg::OP_AMP: begin
				if (val > dcs_pkg::AMP_MAX) val_sat = dcs_pkg::AMP_MAX;
			end
			default: op_ok = 1'b0;
		endcase
	end

	assign s_tready  = !q_full;
	// unused operation codes are taken and dropped
	assign q_push    = s_tvalid && !q_full && op_ok;
	assign q_cmd.op  = op;
	assign q_cmd.ch  = ch;
	assign q_cmd.val = val_sat;
	// f >= ref clock gives a word of 2^32 or more
	assign q_cmd.sat = ({2'b00, val_sat} >= RefC);

endmodule

@@ src/dcs_queue.sv @@
// Small command queue between front end and byte sequencer.
module dcs_queue #(
	parameter int unsigned DEPTH = dcs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dcs_pkg::dcs_cmd_t push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output dcs_pkg::dcs_cmd_t head
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	dcs_pkg::dcs_cmd_t entry_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == FullCnt);
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || (count_q == FullCnt && !do_push))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue pop while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not advance on push");

endmodule

@@ src/dcs_back.sv @@
// Back end: tuning word unit and byte sequencer with output register.
module dcs_back #(
	parameter int unsigned REF_CLOCK_HZ = dcs_pkg::REF_CLOCK_HZ_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_not_empty,
	input  dcs_pkg::dcs_cmd_t           q_head,
	output logic                        q_pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [dcs_pkg::OUT_W-1:0]   m_tdata,
	output logic                        m_tlast
);

	localparam logic [dcs_pkg::REM_W-1:0] RefC = dcs_pkg::REM_W'(REF_CLOCK_HZ);
	// reciprocal floor(2^60 / ref clock), split for two narrow multipliers
	localparam logic [63:0] RecipK  = (64'd1 << 60) / 64'(REF_CLOCK_HZ);
	localparam logic [20:0] RecipLo = RecipK[20:0];
	localparam logic [19:0] RecipHi = RecipK[40:21];

	dcs_pkg::dcs_bk_state_t          state_q, state_d;
	dcs_pkg::dcs_op_t                op_q;
	logic [1:0]                      ch_q;
	logic [dcs_pkg::WORD_W-1:0]      payload_q;
	logic [dcs_pkg::VAL_W-1:0]       f_q;
	logic [48:0]                     prod_lo_q;
	logic [47:0]                     prod_hi_q;
	logic [dcs_pkg::WORD_W-1:0]      quot_q;
	logic [30:0]                     rprod_q;
	logic [1:0]                      div_cnt_q;
	logic [dcs_pkg::IDX_W-1:0]       idx_q;
	logic                            m_valid_q;
	logic [dcs_pkg::OUT_W-1:0]       m_data_q;
	logic                            m_last_q;

	logic                            load;
	logic                            start_div;
	logic [59:0]                     prod_sum;
	logic [30:0]                     rem_v;
	logic                            rem_ge;
	logic [dcs_pkg::IDX_W-1:0]       end_pos;
	logic [7:0]                      byte_v;
	logic                            fs_v;
	logic                            fe_v;
	logic                            upd_v;
	logic                            last_v;

	assign start_div = (q_head.op == dcs_pkg::OP_FREQ) && !q_head.sat;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dcs_pkg::BK_IDLE: begin
				if (q_not_empty) state_d = start_div ? dcs_pkg::BK_DIV : dcs_pkg::BK_SEND;
			end
			dcs_pkg::BK_DIV: begin
				if (div_cnt_q == '0) state_d = dcs_pkg::BK_SEND;
			end
			dcs_pkg::BK_SEND: begin
				if (load && last_v) state_d = dcs_pkg::BK_IDLE;
			end
			default: state_d = dcs_pkg::BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		q_pop = 1'b0;
		load  = 1'b0;
		case (state_q)
			dcs_pkg::BK_IDLE: q_pop = q_not_empty;
			dcs_pkg::BK_SEND: load  = !m_valid_q || m_tready;
			default: begin
				q_pop = 1'b0;
				load  = 1'b0;
			end
		endcase
	end

	// estimate (f * K) >> 28 is the word or one below it; f < ref clock keeps the
	// product under 2^60 and the remainder f * 2^32 - q * ref under 2^31
	assign prod_sum = {prod_hi_q[38:0], 21'd0} + {11'd0, prod_lo_q};
	assign rem_v    = 31'd0 - rprod_q;
	assign rem_ge   = (rem_v >= {1'b0, RefC});

	always_comb begin
		case (op_q)
			dcs_pkg::OP_FREQ:  end_pos = dcs_pkg::POS_FREQ_END;
			dcs_pkg::OP_PHASE: end_pos = dcs_pkg::POS_PHASE_END;
			default:           end_pos = dcs_pkg::POS_AMP_END;
		endcase
	end

	always_comb begin
		fs_v   = 1'b0;
		fe_v   = 1'b0;
		case (idx_q)
			dcs_pkg::POS_CSEL_ADDR: begin
				byte_v = dcs_pkg::ADDR_CSEL;
				fs_v   = 1'b1;
			end
			dcs_pkg::POS_CSEL_DATA: begin
				byte_v = 8'(dcs_pkg::SEL_BASE << ch_q);
				fe_v   = 1'b1;
			end
			dcs_pkg::POS_REG_ADDR: begin
				fs_v = 1'b1;
				case (op_q)
					dcs_pkg::OP_FREQ:  byte_v = dcs_pkg::ADDR_FREQ;
					dcs_pkg::OP_PHASE: byte_v = dcs_pkg::ADDR_PHASE;
					default:           byte_v = dcs_pkg::ADDR_AMP;
				endcase
			end
			default: begin
				byte_v = payload_q[dcs_pkg::WORD_W-1 -: 8];
				fe_v   = (idx_q == end_pos);
			end
		endcase
		last_v = (idx_q == end_pos);
		upd_v  = fe_v && (op_q != dcs_pkg::OP_PHASE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dcs_pkg::BK_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load)          m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q      <= q_head.op;
			ch_q      <= q_head.ch;
			idx_q     <= '0;
			f_q       <= q_head.val;
			div_cnt_q <= 2'd3;
			case (q_head.op)
				dcs_pkg::OP_FREQ:  payload_q <= q_head.sat ? '1 : '0;
				dcs_pkg::OP_PHASE: payload_q <= {q_head.val[15:0], 16'h0000};
				default: payload_q <= {8'h00, dcs_pkg::AMP_ENABLE | q_head.val[15:0], 8'h00};
			endcase
		end else if (state_q == dcs_pkg::BK_DIV) begin
			div_cnt_q <= div_cnt_q - 1'b1;
			case (div_cnt_q)
				2'd3: begin
					prod_lo_q <= {21'd0, f_q} * {28'd0, RecipLo};
					prod_hi_q <= {20'd0, f_q} * {28'd0, RecipHi};
				end
				2'd2:    quot_q    <= prod_sum[59:28];
				2'd1:    rprod_q   <= quot_q[30:0] * {1'b0, RefC};
				default: payload_q <= quot_q + {31'd0, rem_ge};
			endcase
		end else if (load) begin
			idx_q    <= idx_q + 1'b1;
			m_data_q <= {5'b00000, upd_v, fe_v, fs_v, byte_v};
			m_last_q <= last_v;
			if (idx_q > dcs_pkg::POS_REG_ADDR) payload_q <= {payload_q[dcs_pkg::WORD_W-9:0], 8'h00};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tdata[9])
		else $error("last byte does not close a frame");
	a_upd_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[10]) |-> m_tdata[9])
		else $error("update request off a frame end");
	a_div_freq_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dcs_pkg::BK_DIV) |-> (op_q == dcs_pkg::OP_FREQ))
		else $error("divider running for a non-frequency request");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dcs_pkg::BK_SEND && load && !last_v) |=> state_q == dcs_pkg::BK_SEND)
		else $error("sequencer left a command early");

endmodule

@@ src/dds_channel_command_serializer_core.sv @@
// Top level of the DDS channel command serializer.
// Each request (operation in s_tuser, channel and value in s_tdata) becomes two register-write
// frames for a four-channel DDS serial port, one output byte per transfer, MSB first on the wire.
// Frequency requests are dequeued, pass the tuning-word unit (reciprocal multiply plus one
// correction step, skipped when the word saturates) and then send seven bytes. Phase requests
// send five bytes, amplitude requests six. Bytes wait while the output is held off; a two-entry
// queue lets new requests be taken while the back end is still busy.
// Unused operation code 3 is accepted and produces no bytes.
module dds_channel_command_serializer_core #(
	parameter int unsigned REF_CLOCK_HZ = dcs_pkg::REF_CLOCK_HZ_DEF,
	parameter int unsigned QUEUE_DEPTH  = dcs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [dcs_pkg::IN_W-1:0]   s_tdata,   // channel[1:0], value[29:2], zeros
	input  logic [1:0]                 s_tuser,   // operation[1:0]
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [dcs_pkg::OUT_W-1:0]  m_tdata,   // data_byte[7:0], frame_start[8],
	                                              // frame_end[9], update_after[10], zeros
	output logic                       m_tlast    // last
);

	logic              q_push;
	logic              q_full;
	logic              q_pop;
	logic              q_not_empty;
	dcs_pkg::dcs_cmd_t q_in;
	dcs_pkg::dcs_cmd_t q_head;

	dcs_front #(.REF_CLOCK_HZ(REF_CLOCK_HZ)) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_in)
	);

	dcs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	dcs_back #(.REF_CLOCK_HZ(REF_CLOCK_HZ)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the DDS channel command serializer core.
`timescale 1ns / 100ps

module testbench;

	localparam logic [1:0]  OP_UNUSED    = 2'd3;
	localparam logic [63:0] REF_HZ       = 64'(dcs_pkg::REF_CLOCK_HZ_DEF);
	localparam int unsigned RANDOM_CMDS  = 390;
	localparam int unsigned CYCLE_LIMIT  = 300000;
	localparam int unsigned DRAIN_CYCLES = 64;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int          ROWS         = 20;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
		logic       frame_end;
		logic       update_after;
		logic       last;
	} serial_byte_t;

	// fixed_len != 0: register-frame bytes typed in, MSB-aligned in fixed_bytes
	typedef struct packed {
		logic [1:0]  op;
		logic [1:0]  ch;
		logic [27:0] val;
		logic [2:0]  fixed_len;
		logic [39:0] fixed_bytes;
	} cmd_row_t;

	cmd_row_t directed_rows [ROWS] = '{
		'{dcs_pkg::OP_FREQ,  2'd0, 28'd0,         3'd5, 40'h0400000000},
		'{dcs_pkg::OP_FREQ,  2'd1, 28'd250000000, 3'd5, 40'h0480000000},
		'{dcs_pkg::OP_FREQ,  2'd2, 28'hFFFFFFF,   3'd5, 40'h0480000000},
		'{dcs_pkg::OP_FREQ,  2'd0, 28'd250000001, 3'd5, 40'h0480000000},
		'{dcs_pkg::OP_FREQ,  2'd3, 28'd1,         3'd0, 40'h0},
		'{dcs_pkg::OP_FREQ,  2'd3, 28'd100000000, 3'd0, 40'h0},
		'{dcs_pkg::OP_FREQ,  2'd3, 28'd12345678,  3'd0, 40'h0},
		'{dcs_pkg::OP_FREQ,  2'd1, 28'd249999999, 3'd0, 40'h0},
		'{dcs_pkg::OP_PHASE, 2'd0, 28'd0,         3'd3, 40'h0500000000},
		'{dcs_pkg::OP_PHASE, 2'd1, 28'd16383,     3'd3, 40'h053FFF0000},
		'{dcs_pkg::OP_PHASE, 2'd2, 28'd16384,     3'd3, 40'h053FFF0000},
		'{dcs_pkg::OP_PHASE, 2'd3, 28'hFFFFFFF,   3'd3, 40'h053FFF0000},
		'{dcs_pkg::OP_PHASE, 2'd0, 28'd12345,     3'd0, 40'h0},
		'{dcs_pkg::OP_AMP,   2'd0, 28'd0,         3'd4, 40'h0600100000},
		'{dcs_pkg::OP_AMP,   2'd1, 28'd1023,      3'd4, 40'h060013FF00},
		'{dcs_pkg::OP_AMP,   2'd2, 28'd1024,      3'd4, 40'h060013FF00},
		'{dcs_pkg::OP_AMP,   2'd3, 28'hFFFFFFF,   3'd4, 40'h060013FF00},
		'{dcs_pkg::OP_AMP,   2'd2, 28'd512,       3'd0, 40'h0},
		'{OP_UNUSED,         2'd1, 28'd5,         3'd0, 40'h0},
		'{OP_UNUSED,         2'd3, 28'hFFFFFFF,   3'd0, 40'h0}
	};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;

	serial_byte_t pending_bytes[$];
	int unsigned  commands_sent = 0;
	int unsigned  bytes_checked = 0;
	int unsigned  error_count   = 0;
	int unsigned  cycle_count   = 0;
	int unsigned  hold_left     = 0;
	bit           hold_done     = 1'b0;

	dds_channel_command_serializer_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	// address byte and payload of the register frame, MSB-aligned; len 0 = no output
	function automatic void predict_register_frame(input logic [1:0] op,
			input logic [27:0] val, output logic [39:0] frame, output int unsigned len);
		logic [63:0] word;
		logic [27:0] sat;
		logic [15:0] amp_word;
		frame = '0;
		len   = 0;
		case (op)
			dcs_pkg::OP_FREQ: begin
				sat  = (val > dcs_pkg::FREQ_MAX) ? dcs_pkg::FREQ_MAX : val;
				word = {4'b0, sat, 32'b0} / REF_HZ;
				if (word > 64'hFFFFFFFF)
					word = 64'hFFFFFFFF;
				frame = {dcs_pkg::ADDR_FREQ, word[31:0]};
				len   = 5;
			end
			dcs_pkg::OP_PHASE: begin
				sat   = (val > dcs_pkg::PHASE_MAX) ? dcs_pkg::PHASE_MAX : val;
				frame = {dcs_pkg::ADDR_PHASE, sat[15:0], 16'h0};
				len   = 3;
			end
			dcs_pkg::OP_AMP: begin
				sat      = (val > dcs_pkg::AMP_MAX) ? dcs_pkg::AMP_MAX : val;
				amp_word = sat[15:0] | dcs_pkg::AMP_ENABLE;
				frame    = {dcs_pkg::ADDR_AMP, 8'h00, amp_word, 8'h00};
				len      = 4;
			end
			default: ;
		endcase
	endfunction

	// channel-select frame, then the register frame
	task automatic queue_frames(input logic [1:0] op, input logic [1:0] ch,
			input logic [39:0] frame, input int unsigned len);
		serial_byte_t b;
		logic         upd;
		logic [7:0]   sel;
		if (len == 0)
			return;
		upd = (op != dcs_pkg::OP_PHASE);
		sel = dcs_pkg::SEL_BASE << ch;
		pending_bytes.push_back('{dcs_pkg::ADDR_CSEL, 1'b1, 1'b0, 1'b0, 1'b0});
		pending_bytes.push_back('{sel, 1'b0, 1'b1, upd, 1'b0});
		for (int i = 0; i < len; i++) begin
			b.data_byte    = frame[39 - 8*i -: 8];
			b.frame_start  = (i == 0);
			b.frame_end    = (i == len - 1);
			b.update_after = b.frame_end && upd;
			b.last         = b.frame_end;
			pending_bytes.push_back(b);
		end
	endtask

	task automatic send_command(input logic [1:0] op, input logic [1:0] ch,
			input logic [27:0] val, input bit calm);
		while (!calm && $urandom_range(99) < 38) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, val, ch};
		do @(posedge clk); while (!s_tready);
		commands_sent++;
	endtask

	function automatic logic [27:0] pick_value(input logic [1:0] op);
		logic [27:0] top;
		int unsigned kind;
		top  = (op == dcs_pkg::OP_FREQ) ? dcs_pkg::FREQ_MAX :
			(op == dcs_pkg::OP_PHASE) ? dcs_pkg::PHASE_MAX : dcs_pkg::AMP_MAX;
		kind = $urandom_range(9);
		if (kind == 0)
			return 28'($urandom());
		if (kind == 1)
			return top + 28'($urandom_range(2)) - 28'd1;  // around saturation
		if (kind == 2)
			return 28'($urandom_range(3));
		return 28'($urandom_range(top));
	endfunction

	initial begin
		logic [1:0]  op;
		logic [1:0]  ch;
		logic [27:0] val;
		logic [39:0] frame;
		int unsigned len;
		int unsigned counted;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_command(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].val, 1'b0);
			if (directed_rows[i].fixed_len != 0) begin
				queue_frames(directed_rows[i].op, directed_rows[i].ch,
					directed_rows[i].fixed_bytes, directed_rows[i].fixed_len);
			end else begin
				predict_register_frame(directed_rows[i].op, directed_rows[i].val, frame, len);
				queue_frames(directed_rows[i].op, directed_rows[i].ch, frame, len);
			end
		end

		counted = 0;
		while (counted < RANDOM_CMDS) begin
			op  = ($urandom_range(19) == 0) ? OP_UNUSED : 2'($urandom_range(2));
			ch  = 2'($urandom_range(3));
			val = pick_value(op);
			// sender runs back to back for a stretch
			send_command(op, ch, val, counted >= 120 && counted < 200);
			predict_register_frame(op, val, frame, len);
			queue_frames(op, ch, frame, len);
			if (op != OP_UNUSED)
				counted++;
		end
		s_tvalid <= 1'b0;

		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// receiver: one long hold-off to back the block up, a calm stretch, random stalls otherwise
	always @(posedge clk) begin
		if (!hold_done && commands_sent >= 60) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (bytes_checked >= 1200 && bytes_checked < 1800) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= 38);
		end
	end

	always @(posedge clk) begin
		serial_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_bytes.size() == 0) begin
				$error("unexpected byte: data_byte %0h", m_tdata[7:0]);
				error_count++;
			end else begin
				want = pending_bytes.pop_front();
				bytes_checked++;
				if (m_tdata[7:0] !== want.data_byte) begin
					$error("data_byte: expected %0h, got %0h", want.data_byte, m_tdata[7:0]);
					error_count++;
				end
				if (m_tdata[8] !== want.frame_start) begin
					$error("frame_start: expected %0b, got %0b", want.frame_start, m_tdata[8]);
					error_count++;
				end
				if (m_tdata[9] !== want.frame_end) begin
					$error("frame_end: expected %0b, got %0b", want.frame_end, m_tdata[9]);
					error_count++;
				end
				if (m_tdata[10] !== want.update_after) begin
					$error("update_after: expected %0b, got %0b", want.update_after, m_tdata[10]);
					error_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, m_tlast);
					error_count++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench: done, errors");
		$finish;
	end

endmodule

@@ dds_channel_command_serializer_core.f @@
src/dcs_pkg.sv
src/dcs_front.sv
src/dcs_queue.sv
src/dcs_back.sv
src/dds_channel_command_serializer_core.sv
tb/sv/testbench.sv
